[sv/btrd_pkg.sv]
// Shared types, constants and helper functions for the radix digit converter.
`default_nettype none

package btrd_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;  // 'A'
    localparam logic [DIGIT_W-1:0] DEC_MAX   = 4'd9;
    localparam logic [DIGIT_W-1:0] DEC_TEN   = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ZERO,
        ST_READ,
        ST_EMIT
    } state_t;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        else
            res = r;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d <= DEC_MAX)
            res = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        else
            res = CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_TEN};
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/btrd_div_unit.sv]
// Bit-serial restoring divider of a binary value by a small radix, one quotient bit per cycle.
`default_nettype none

module btrd_div_unit #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [VALUE_BITS-1:0]         dividend,
    input  wire logic [btrd_pkg::RADIX_W-1:0]  radix,
    output logic                               done,
    output logic [VALUE_BITS-1:0]              quotient,
    output logic [btrd_pkg::DIGIT_W-1:0]       remainder
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]             val_reg, val_next;
    logic [btrd_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [btrd_pkg::RADIX_W-1:0]      radix_reg, radix_next;

    logic [btrd_pkg::RADIX_W-1:0]      trial;
    logic [btrd_pkg::RADIX_W-1:0]      diff;
    logic                              ge;

    // remainder stays below radix <= 16, so the shifted trial fits five bits
    assign trial = {rem_reg, val_reg[VALUE_BITS-1]};
    assign ge    = (trial >= radix_reg);
    assign diff  = trial - radix_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            val_next   = dividend;
            rem_next   = '0;
            radix_next = radix;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[btrd_pkg::DIGIT_W-1:0] : trial[btrd_pkg::DIGIT_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    assign done      = done_reg;
    assign quotient  = val_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/binary_to_radix_digits.sv]
// Top level: converts a binary value into upper-case ASCII digits of a base from 2 to 16.
//
//   channel | role   | tdata                                  | tlast   | tuser
//   s_*     | input  | [VB-1:0] value, [VB+4:VB] radix        | -       | -
//   m_*     | output | [7:0] digit_char                       | is_last | [0] palindrome,
//           |        |                                        |         | [1] no_digits
//
// Each digit is produced by the bit-serial divider and written to the digit store; for
// each digit in turn the store is then read (two read ports, ST_READ) and the output register
// loaded (ST_EMIT); control then returns to idle, in which the next value is taken, and a
// zero value goes from idle through ST_ZERO straight back to idle.
// s_tready is high only between conversions; the next value is taken while the last
// digit still sits in the output register. m_tready low holds the output register and
// stalls the emission. Reset (rst_n, asynchronous) returns the control to idle.
`default_nettype none

module binary_to_radix_digits #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // [VALUE_BITS-1:0] value, then 5 bits radix, zero padded to whole bytes
    input  wire logic [((VALUE_BITS+btrd_pkg::RADIX_W+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // [7:0] digit_char
    output logic [btrd_pkg::CHAR_W-1:0] m_tdata,
    output logic      m_tlast,
    // [0] palindrome, [1] no_digits
    output logic [1:0] m_tuser
);

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

    logic [VALUE_BITS-1:0]            s_value;
    logic [btrd_pkg::RADIX_W-1:0]     s_radix;
    logic                             s_fire;

    btrd_pkg::state_t                 state_reg, state_next;
    logic [CNT_W-1:0]                 n_reg, n_next;
    logic [ADDR_W-1:0]                k_reg, k_next;
    logic [btrd_pkg::RADIX_W-1:0]     radix_reg, radix_next;
    logic                             pal_reg, pal_next;

    logic                             out_valid_reg, out_valid_next;
    logic [btrd_pkg::CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_pal_reg, out_pal_next;
    logic                             out_none_reg, out_none_next;
    logic                             out_free;

    logic                             div_start;
    logic [VALUE_BITS-1:0]            div_dividend;
    logic [btrd_pkg::RADIX_W-1:0]     div_radix;
    logic                             div_done;
    logic [VALUE_BITS-1:0]            div_quot;
    logic [btrd_pkg::DIGIT_W-1:0]     div_rem;

    logic [btrd_pkg::DIGIT_W-1:0]     store_mem [MAX_DIGITS];
    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [CNT_W-1:0]                 rd_pos_a;
    logic [ADDR_W-1:0]                rd_addr_a, rd_addr_b;
    logic [btrd_pkg::DIGIT_W-1:0]     rd_a_reg, rd_b_reg;
    logic                             emit_last;
    logic                             digits_eq;

    assign s_value  = s_tdata[VALUE_BITS-1:0];
    assign s_radix  = s_tdata[VALUE_BITS +: btrd_pkg::RADIX_W];
    assign s_tready = (state_reg == btrd_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    btrd_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (div_radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // emitted digit comes from the top of the store, its mirror from the bottom
    assign rd_pos_a  = n_reg - CNT_W'(1) - CNT_W'(k_reg);
    assign rd_addr_a = rd_pos_a[ADDR_W-1:0];
    assign rd_addr_b = k_reg;
    assign wr_addr   = n_reg[ADDR_W-1:0];
    assign emit_last = (CNT_W'(k_reg) == (n_reg - CNT_W'(1)));
    assign digits_eq = (rd_a_reg == rd_b_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        radix_next     = radix_reg;
        pal_next       = pal_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_pal_next   = out_pal_reg;
        out_none_next  = out_none_reg;
        div_start      = 1'b0;
        div_dividend   = div_quot;
        div_radix      = radix_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            btrd_pkg::ST_IDLE:
            begin
                div_dividend = s_value;
                div_radix    = btrd_pkg::sat_radix(s_radix);
                if (s_fire)
                begin
                    radix_next = btrd_pkg::sat_radix(s_radix);
                    n_next     = '0;
                    k_next     = '0;
                    pal_next   = 1'b1;
                    if (s_value == '0)
                        state_next = btrd_pkg::ST_ZERO;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = btrd_pkg::ST_DIV;
                    end
                end
            end

            btrd_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    wr_en  = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                    // stop on a zero quotient or a full digit store
                    if ((div_quot == '0) || (n_reg == CNT_LAST))
                        state_next = btrd_pkg::ST_READ;
                    else
                        div_start = 1'b1;
                end
            end

            btrd_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_last_next  = 1'b1;
                    out_pal_next   = 1'b1;
                    out_none_next  = 1'b1;
                    state_next     = btrd_pkg::ST_IDLE;
                end
            end

            btrd_pkg::ST_READ:
            begin
                state_next = btrd_pkg::ST_EMIT;
            end

            btrd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    pal_next       = pal_reg && digits_eq;
                    out_valid_next = 1'b1;
                    out_char_next  = btrd_pkg::digit_to_ascii(rd_a_reg);
                    out_last_next  = emit_last;
                    out_pal_next   = emit_last && pal_reg && digits_eq;
                    out_none_next  = 1'b0;
                    k_next         = k_reg + ADDR_W'(1);
                    state_next     = emit_last ? btrd_pkg::ST_IDLE : btrd_pkg::ST_READ;
                end
            end

            default:
            begin
                state_next = btrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btrd_pkg::ST_IDLE;
            n_reg         <= '0;
            k_reg         <= '0;
            pal_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            pal_reg       <= pal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_pal_reg  <= out_pal_next;
        out_none_reg <= out_none_next;
    end

    // digit store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= div_rem;
        rd_a_reg <= store_mem[rd_addr_a];
        rd_b_reg <= store_mem[rd_addr_b];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_none_reg, out_pal_reg};

endmodule

`default_nettype wire

[sv/btrd_checker.sv]
// Port-level checks on the converter's result stream, bound to the top level.
`default_nettype none

module btrd_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic       m_tlast,
    input  wire logic [1:0] m_tuser
);

    // a stalled transaction keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
    else $error("output transaction changed while stalled");

    // empty string result: single final transaction, zero char, palindrome set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] && (m_tdata == 8'h00))
    else $error("malformed no_digits transaction");

    // palindrome and no_digits flags only on the final transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser[0] && !m_tuser[1])
    else $error("flag set on non-final digit");

    // digit characters are '0'-'9' or 'A'-'F'
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |->
            ((m_tdata >= 8'h30) && (m_tdata <= 8'h39))
            || ((m_tdata >= 8'h41) && (m_tdata <= 8'h46)))
    else $error("digit character out of range");

endmodule

bind binary_to_radix_digits btrd_checker u_btrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/binary_to_radix_digits_test.sv]
// Self-checking testbench for the binary to radix digit converter.
`default_nettype none

module binary_to_radix_digits_test;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 31;
    localparam int DATA_W     = ((VALUE_BITS + btrd_pkg::RADIX_W + 7) / 8) * 8;
    localparam longint VALUE_MAX = (longint'(1) << VALUE_BITS) - 1;

    typedef struct packed {
        logic [btrd_pkg::CHAR_W-1:0] digit_char;
        logic                        is_last;
        logic                        palindrome;
        logic                        no_digits;
    } digit_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [DATA_W-1:0]           s_tdata;     // [30:0] value, [35:31] radix, [39:36] zero
    logic                        m_tvalid;
    logic                        m_tready;
    logic [btrd_pkg::CHAR_W-1:0] m_tdata;     // [7:0] digit_char
    logic                        m_tlast;
    logic [1:0]                  m_tuser;     // [0] palindrome, [1] no_digits

    digit_result_t expected_digits[$];

    int send_idle_pct;
    int recv_stall_pct;
    int ready_hold_cycles;
    int values_sent;
    int digits_checked;
    int error_count;
    int zero_values;
    int palindromes_seen;
    int saturated_radixes;

    binary_to_radix_digits #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(60_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Expected digit string for one conversion, most significant digit first.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                           input logic [btrd_pkg::RADIX_W-1:0] radix);
        logic [btrd_pkg::DIGIT_W-1:0] digs[MAX_DIGITS];
        logic [31:0]                  rem;
        int                           base;
        int                           n;
        int                           i;
        bit                           pal;
        digit_result_t                res;
        base = int'(radix);
        if (radix < btrd_pkg::RADIX_MIN || radix > btrd_pkg::RADIX_MAX)
            saturated_radixes++;
        if (base < 2)
            base = 2;
        if (base > 16)
            base = 16;
        rem = 32'(value);
        n = 0;
        while (rem != 0 && n < MAX_DIGITS)
        begin
            digs[n] = btrd_pkg::DIGIT_W'(rem % base);
            rem = rem / base;
            n++;
        end
        if (n == 0)
        begin
            zero_values++;
            res = '{digit_char: '0, is_last: 1'b1, palindrome: 1'b1, no_digits: 1'b1};
            expected_digits = {expected_digits, res};
            return;
        end
        pal = 1'b1;
        for (i = 0; i < n / 2; i++)
            if (digs[i] != digs[n-1-i])
                pal = 1'b0;
        for (i = n - 1; i >= 0; i--)
        begin
            if (digs[i] <= btrd_pkg::DEC_MAX)
                res.digit_char = btrd_pkg::CHAR_ZERO + digs[i];
            else
                res.digit_char = btrd_pkg::CHAR_A + (digs[i] - btrd_pkg::DEC_TEN);
            res.is_last    = (i == 0);
            res.palindrome = (i == 0) && pal;
            res.no_digits  = 1'b0;
            expected_digits = {expected_digits, res};
        end
    endfunction

    // Palindromic value in the given base that fits the value field.
    function automatic logic [VALUE_BITS-1:0] make_palindrome(input int base);
        logic [btrd_pkg::DIGIT_W-1:0] digs[MAX_DIGITS];
        longint                       acc;
        longint                       m;
        int                           len;
        int                           max_len;
        int                           i;
        m = VALUE_MAX;
        max_len = 0;
        while (m != 0)
        begin
            m = m / base;
            max_len++;
        end
        len = $urandom_range(1, max_len);
        do
        begin
            for (i = 0; i < (len + 1) / 2; i++)
            begin
                digs[i] = (i == 0) ? btrd_pkg::DIGIT_W'($urandom_range(1, base - 1))
                                   : btrd_pkg::DIGIT_W'($urandom_range(0, base - 1));
                digs[len-1-i] = digs[i];
            end
            acc = 0;
            for (i = 0; i < len; i++)
                acc = acc * base + digs[i];
            if (acc > VALUE_MAX)
                len--;
        end while (acc > VALUE_MAX);
        return VALUE_BITS'(acc);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_value(input logic [VALUE_BITS-1:0] value,
                              input logic [btrd_pkg::RADIX_W-1:0] radix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(DATA_W-VALUE_BITS-btrd_pkg::RADIX_W){1'b0}}, radix, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_digits(value, radix);
        values_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_for_digits();
        while (expected_digits.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold_cycles > 0)
            begin
                m_tready = 1'b0;
                ready_hold_cycles--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        digit_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit transaction: digit_char %h tlast %b tuser %b",
                       m_tdata, m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                exp_res = expected_digits.pop_front();
                digits_checked++;
                if (m_tdata !== exp_res.digit_char)
                begin
                    $error("digit_char mismatch: expected %h, got %h",
                           exp_res.digit_char, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_res.is_last)
                begin
                    $error("is_last mismatch: expected %b, got %b", exp_res.is_last, m_tlast);
                    error_count++;
                end
                if (m_tuser[0] !== exp_res.palindrome)
                begin
                    $error("palindrome mismatch: expected %b, got %b",
                           exp_res.palindrome, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== exp_res.no_digits)
                begin
                    $error("no_digits mismatch: expected %b, got %b",
                           exp_res.no_digits, m_tuser[1]);
                    error_count++;
                end
                if (exp_res.is_last && exp_res.palindrome && !exp_res.no_digits)
                    palindromes_seen++;
            end
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_value(31'd0, 5'd10);
        send_value(31'd0, 5'd31);
        send_value(31'h7FFF_FFFF, 5'd2);
        send_value(31'h7FFF_FFFF, 5'd16);
        send_value(31'h7FFF_FFFF, 5'd10);
        send_value(31'h7FFF_FFFF, 5'd0);
        send_value(31'h7FFF_FFFF, 5'd1);
        send_value(31'h7FFF_FFFF, 5'd17);
        send_value(31'h7FFF_FFFF, 5'd31);
        send_value(31'd1, 5'd2);
        send_value(31'd1, 5'd16);
        send_value(31'd15, 5'd16);
        send_value(31'd10, 5'd16);
        send_value(31'd9, 5'd10);
        send_value(31'd585, 5'd10);
        send_value(31'd586, 5'd10);
        send_value(31'd255, 5'd16);
        send_value(31'h4000_0000, 5'd2);
        send_value(31'h1555_5555, 5'd2);
        send_value(31'h2AAA_AAAA, 5'd2);
        send_value(31'd2147483646, 5'd3);
        send_value(31'd80, 5'd9);
        send_value(31'd1, 5'd0);
        wait_for_digits();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [VALUE_BITS-1:0]         value;
        logic [btrd_pkg::RADIX_W-1:0]  radix;
        int                            kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 85)
                radix = btrd_pkg::RADIX_W'($urandom_range(2, 16));
            else
                radix = btrd_pkg::RADIX_W'($urandom_range(0, 31));
            kind = $urandom_range(99);
            if (kind < 30)
                value = make_palindrome((radix < 2) ? 2 : (radix > 16) ? 16 : radix);
            else if (kind < 38)
                value = VALUE_BITS'(make_palindrome((radix < 2) ? 2 :
                                                    (radix > 16) ? 16 : radix) + 1);
            else if (kind < 46)
                value = '0;
            else if (kind < 70)
                value = VALUE_BITS'($urandom);
            else
                value = VALUE_BITS'($urandom & ((32'd1 << $urandom_range(1, VALUE_BITS)) - 1));
            send_value(value, radix);
        end
        // sender holds off until the converter has fully drained
        wait_for_digits();
    endtask

    // Long receiver stall while the sender keeps offering values.
    task automatic test_output_stall();
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        ready_hold_cycles = 500;
        repeat (8)
            send_value(VALUE_BITS'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1)),
                       btrd_pkg::RADIX_W'($urandom_range(8, 16)));
        wait_for_digits();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        ready_hold_cycles = 0;
        values_sent       = 0;
        digits_checked    = 0;
        error_count       = 0;
        zero_values       = 0;
        palindromes_seen  = 0;
        saturated_radixes = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(90, 0, 0);
        test_random(90, 67, 0);
        test_random(90, 0, 67);
        test_output_stall();
        test_random(90, 8, 8);

        wait_for_digits();
        repeat (40) @(posedge clk);

        $display("Converted %0d values (%0d zero, %0d with saturated base) into %0d digits",
                 values_sent, zero_values, saturated_radixes, digits_checked);
        $display("Palindromic digit strings flagged: %0d; errors: %0d",
                 palindromes_seen, error_count);
        if (error_count == 0 && expected_digits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
